// File: rtl/core/hufftb_pkg.sv
// hufftb_pkg: constants and types for the huffman total bits block
// no dependencies
package hufftb_pkg;
    localparam int ALPHA_SIZE  = 256;
    localparam int ADDR_W      = 8;
    localparam int IDX_W       = 9;
    localparam int COUNT_W     = 24;
    localparam int WEIGHT_W    = COUNT_W + 8;
    localparam int TOTAL_W     = 32;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;

    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [IDX_W-1:0]    t_idx;

    localparam t_count COUNT_MAX = {COUNT_W{1'b1}};
endpackage

// File: rtl/core/huffman_total_bits.sv
// huffman_total_bits: byte histogram and huffman coded length, top level
// depends on hufftb_pkg
//
// Bytes stream in one word per cycle while tready is high; a count memory
// is updated by read-modify-write with one forwarding register. After the
// tlast word the block sweeps the 256 counts (clearing them as it goes)
// into a weight memory, then merges the two smallest weights n-1 times;
// each merge scans the n live weights through the weight memory read port
// and writes the sum back in a WR1 step and, unless one of the two is the
// last live weight, a WR2 step.
// Input is held off during that work; the result sits in an output register
// so the next message may start while it waits. After reset a clearing pass
// over the count memory runs before the first word is taken.
module huffman_total_bits (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [hufftb_pkg::IN_DATA_W-1:0]    i_s_tdata,  // data_byte
    input  logic                                i_s_tlast,  // end_of_message
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // total_bits[31:0], distinct_symbols[40:32], count_saturated[41]
    output logic [hufftb_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import hufftb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_RUN, ST_LOAD, ST_SCAN, ST_WR1, ST_WR2, ST_DONE
    } t_state;

    t_count  cmem [ALPHA_SIZE];
    t_weight wmem [ALPHA_SIZE];

    t_state  r_state;
    t_idx    r_addr;
    logic    r_v1, r_last1;
    logic [ADDR_W-1:0] r_b1;
    t_count  r_cq;
    logic    r_fv;
    logic [ADDR_W-1:0] r_fb;
    t_count  r_fval;
    logic    r_sat;
    logic    r_ldv;
    logic [ADDR_W-1:0] r_ldi;
    t_idx    r_n, r_distinct;
    t_weight r_wq;
    logic    r_sv;
    logic [ADDR_W-1:0] r_si;
    logic [WEIGHT_W:0] r_m1, r_m2;
    logic [ADDR_W-1:0] r_i1, r_i2;
    t_weight r_lastw;
    logic [TOTAL_W-1:0] r_total;
    logic    r_ov;
    logic [OUT_DATA_W-1:0] r_odata;

    logic    accept, c_we, w_we;
    logic [ADDR_W-1:0] c_ra, c_wa, w_ra, w_wa;
    t_count  c_wd, old_cnt, new_cnt;
    t_weight w_wd, msum;
    logic [TOTAL_W:0] tsum;
    logic [ADDR_W-1:0] last_idx;

    assign o_s_tready = (r_state == ST_RUN) && !(r_v1 && r_last1);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

    assign old_cnt  = (r_fv && r_fb == r_b1) ? r_fval : r_cq;
    assign new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + t_count'(1);
    assign msum     = r_m1[WEIGHT_W-1:0] + r_m2[WEIGHT_W-1:0];
    assign tsum     = {1'b0, r_total} + {1'b0, msum};
    assign last_idx = ADDR_W'(r_n - t_idx'(1));

    always_comb begin
        c_ra = (r_state == ST_LOAD) ? r_addr[ADDR_W-1:0] : i_s_tdata;
        c_we = 1'b0;
        c_wa = r_b1;
        c_wd = new_cnt;
        if (r_state == ST_CLEAR) begin
            c_we = !r_addr[IDX_W-1];
            c_wa = r_addr[ADDR_W-1:0];
            c_wd = '0;
        end else if (r_state == ST_LOAD) begin
            c_we = r_ldv;
            c_wa = r_ldi;
            c_wd = '0;
        end else if (r_v1) begin
            c_we = 1'b1;
        end
        w_ra = r_addr[ADDR_W-1:0];
        w_we = 1'b0;
        w_wa = r_i1;
        w_wd = msum;
        case (r_state)
            ST_LOAD: begin
                w_we = r_ldv && (r_cq != '0);
                w_wa = r_n[ADDR_W-1:0];
                w_wd = WEIGHT_W'(r_cq);
            end
            ST_WR1: begin
                w_we = 1'b1;
                w_wa = (r_i1 == last_idx) ? r_i2 : r_i1;
            end
            ST_WR2: begin
                w_we = 1'b1;
                w_wa = r_i2;
                w_wd = r_lastw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cq <= cmem[c_ra];
        if (c_we) cmem[c_wa] <= c_wd;
        r_wq <= wmem[w_ra];
        if (w_we) wmem[w_wa] <= w_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
            r_fv    <= 1'b0;
            r_sat   <= 1'b0;
            r_ldv   <= 1'b0;
            r_sv    <= 1'b0;
            r_n     <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_tready && r_state != ST_DONE) r_ov <= 1'b0;
            r_v1    <= accept;
            r_last1 <= i_s_tlast;
            r_b1    <= i_s_tdata;
            r_fv    <= r_v1;
            r_fb    <= r_b1;
            r_fval  <= new_cnt;
            if (r_v1 && new_cnt == COUNT_MAX) r_sat <= 1'b1;
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + t_idx'(1);
                    if (r_addr[IDX_W-1]) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_addr <= '0;
                    r_n    <= '0;
                    if (r_v1 && r_last1) begin
                        r_state <= ST_LOAD;
                        r_ldv   <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    r_ldv <= !r_addr[IDX_W-1];
                    r_ldi <= r_addr[ADDR_W-1:0];
                    if (!r_addr[IDX_W-1]) r_addr <= r_addr + t_idx'(1);
                    if (r_ldv && r_cq != '0) r_n <= r_n + t_idx'(1);
                    if (r_addr[IDX_W-1] && !r_ldv) begin
                        r_distinct <= r_n;
                        r_total    <= '0;
                        r_addr     <= '0;
                        r_sv       <= 1'b0;
                        r_m1       <= {1'b1, {WEIGHT_W{1'b0}}};
                        r_m2       <= {1'b1, {WEIGHT_W{1'b0}}};
                        r_state    <= (r_n < t_idx'(2)) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_sv <= (r_addr < r_n);
                    r_si <= r_addr[ADDR_W-1:0];
                    if (r_addr < r_n) r_addr <= r_addr + t_idx'(1);
                    if (r_sv) begin
                        if ({1'b0, r_wq} < r_m1) begin
                            r_m2 <= r_m1;
                            r_i2 <= r_i1;
                            r_m1 <= {1'b0, r_wq};
                            r_i1 <= r_si;
                        end else if ({1'b0, r_wq} < r_m2) begin
                            r_m2 <= {1'b0, r_wq};
                            r_i2 <= r_si;
                        end
                        if (r_si == last_idx) r_lastw <= r_wq;
                    end
                    if (!(r_addr < r_n) && !r_sv) r_state <= ST_WR1;
                end
                ST_WR1: begin
                    r_total <= tsum[TOTAL_W] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
                    if (r_i1 != last_idx && r_i2 != last_idx) begin
                        r_state <= ST_WR2;
                    end else begin
                        r_n     <= r_n - t_idx'(1);
                        r_state <= (r_n == t_idx'(2)) ? ST_DONE : ST_SCAN;
                    end
                    r_addr <= '0;
                    r_m1   <= {1'b1, {WEIGHT_W{1'b0}}};
                    r_m2   <= {1'b1, {WEIGHT_W{1'b0}}};
                end
                ST_WR2: begin
                    r_n     <= r_n - t_idx'(1);
                    r_state <= (r_n == t_idx'(2)) ? ST_DONE : ST_SCAN;
                end
                ST_DONE: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {6'b0, r_sat, r_distinct, r_total};
                        r_sat   <= 1'b0;
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end
endmodule

// File: rtl/core/huffman_total_bits_chk.sv
// huffman_total_bits_chk: port level checks for huffman_total_bits
// depends on huffman_total_bits ports, bound below
module huffman_total_bits_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word dropped or changed while stalled");
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after last word");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[40:32] == 9'd0 || o_m_tdata[40:32] == 9'd1)
        |-> o_m_tdata[31:0] == 32'd0)
        else $error("nonzero total for fewer than two symbols");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("ports active right after reset");
endmodule

bind huffman_total_bits huffman_total_bits_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .i_s_tlast(i_s_tlast), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
